// ===== rtl/core/mpid_pkg.sv =====
// shared constants and types for the multichannel incremental pid heater
// no dependencies; compile first

package mpid_pkg;

	// channel count and field widths
	localparam int NUM_CHANNELS = 12;
	localparam int CH_W         = 4;
	localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int TEMP_W       = 21;
	localparam int SP_W         = 21;
	localparam int GAIN_W       = 24;
	localparam int DUTY_W       = 7;
	localparam int RAW_W        = 48;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 2'd3;

	localparam logic signed [SP_W-1:0] SETPOINT_RESET = 21'sd36600;
	localparam logic [GAIN_W-1:0]      GAIN_P_RESET   = 24'd65536;
	localparam logic [GAIN_W-1:0]      GAIN_I_RESET   = 24'd655;
	localparam logic [GAIN_W-1:0]      GAIN_D_RESET   = 24'd655;

	// datapath widths
	localparam int SUM_W  = TEMP_W + 4;      // 9*sample + heater
	localparam int MAG_W  = SUM_W - 1;       // magnitude of that sum
	localparam int Q_W    = TEMP_W;          // blend magnitude
	localparam int ERR_W  = Q_W + 1;         // signed error
	localparam int A_W    = GAIN_W + 2;      // coefficient magnitudes
	localparam int PROD_W = A_W + 1 + ERR_W; // one coefficient product
	localparam int ACC_W  = PROD_W + 1;      // sum of three products
	localparam int FRAC_W = 16;              // q8.16 gains
	localparam int SH_W   = ACC_W - FRAC_W;
	localparam int YS_W   = RAW_W + 1;

	// divide by ten through a reciprocal, exact for the magnitude range
	localparam int              DIV10_SHIFT = 29;
	localparam int              DIV10_MUL_W = 26;
	localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 26'd53687092;

	// milli-percent to whole percent, exact below full scale
	localparam int                     DUTY_IN_W   = 17;
	localparam int                     DUTY_SHIFT  = 27;
	localparam int                     DUTY_MUL_W  = 18;
	localparam logic [DUTY_MUL_W-1:0]  DUTY_MUL    = 18'd134218;
	localparam logic signed [RAW_W-1:0] DUTY_FULL_MILLI = 48'sd100000;
	localparam logic [DUTY_W-1:0]      DUTY_MAX    = 7'd100;

	// per-channel controller state, one memory word
	typedef struct packed {
		logic signed [ERR_W-1:0] e1;
		logic signed [ERR_W-1:0] e2;
		logic signed [RAW_W-1:0] y1;
	} pid_state_t;

	localparam int MEM_W = $bits(pid_state_t);

endpackage

// ===== rtl/core/mpid_in_if.sv =====
// request channel carrying one temperature reading per channel
// depends on mpid_pkg

interface mpid_in_if;
	logic                               valid;
	logic                               ready;
	logic [mpid_pkg::CH_W-1:0]          channel;
	logic signed [mpid_pkg::TEMP_W-1:0] sample_temp;
	logic signed [mpid_pkg::TEMP_W-1:0] heater_temp;

	modport source (output valid, output channel, output sample_temp, output heater_temp,
		input ready);
	modport sink (input valid, input channel, input sample_temp, input heater_temp,
		output ready);
endinterface

// ===== rtl/core/mpid_out_if.sv =====
// request channel carrying one duty result per reading
// depends on mpid_pkg

interface mpid_out_if;
	logic                              valid;
	logic                              ready;
	logic [mpid_pkg::CH_W-1:0]         out_channel;
	logic [mpid_pkg::DUTY_W-1:0]       duty_percent;
	logic signed [mpid_pkg::RAW_W-1:0] pid_raw;

	modport source (output valid, output out_channel, output duty_percent, output pid_raw,
		input ready);
	modport sink (input valid, input out_channel, input duty_percent, input pid_raw,
		output ready);
endinterface

// ===== rtl/core/mpid_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module mpid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/multichannel_incremental_pid_heater_top.sv =====
// throughput: one request per cycle while no channel recurs within six requests and the result is not held back
// a channel's state is read from the ram at accept and written back as its request moves
// from stage 5 to stage 6, and a request for a channel still in that window waits
// reset: gains and setpoint return to their defaults, every channel state reads as zero at once
// top level; depends on mpid_pkg, mpid_in_if, mpid_out_if and mpid_ram

module multichannel_incremental_pid_heater_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	mpid_in_if.sink                              reading,
	mpid_out_if.source                           result,
	input  logic                                 cfg_we,
	input  logic [mpid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mpid_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// control that travels with each request down the pipe
	typedef struct packed {
		logic                      vld;
		logic                      inr;
		logic [mpid_pkg::CH_W-1:0] ch;
	} stage_ctl_t;

	// configuration registers
	logic signed [mpid_pkg::SP_W-1:0] setpoint_q;
	logic [mpid_pkg::GAIN_W-1:0]      gain_p_q;
	logic [mpid_pkg::GAIN_W-1:0]      gain_i_q;
	logic [mpid_pkg::GAIN_W-1:0]      gain_d_q;

	// incremental form coefficients, recomputed every cycle from the gains
	logic [mpid_pkg::A_W-1:0]          coef_a0_q;
	logic signed [mpid_pkg::A_W:0]     coef_a1_q;
	logic signed [mpid_pkg::GAIN_W:0]  coef_a2_q;
	logic [mpid_pkg::A_W-1:0]          a1_mag;

	// pipeline control
	stage_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic       out_valid_q;
	logic       en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_out;
	logic       hazard, accept, in_range_in;
	logic [mpid_pkg::CH_AW-1:0] rd_addr;

	// reset-cleared marker per channel: unwritten entries read as zero
	logic [mpid_pkg::NUM_CHANNELS-1:0] ent_valid_q;

	// ram
	logic                       ram_we;
	logic [mpid_pkg::CH_AW-1:0] ram_waddr;
	mpid_pkg::pid_state_t       ram_wdata, ram_rdata;

	// stage 1: blended sum split into sign and magnitude
	logic signed [mpid_pkg::SUM_W-1:0] sum9;
	logic                              sum_neg;
	logic [mpid_pkg::MAG_W-1:0]        sum_mag;
	logic                              neg_s1, hit_s1;
	logic [mpid_pkg::MAG_W-1:0]        mag_s1;

	// stage 2: blend magnitude and fetched state
	logic [mpid_pkg::MAG_W+mpid_pkg::DIV10_MUL_W-1:0] div_prod;
	logic [mpid_pkg::Q_W-1:0]  q_s2;
	logic                      neg_s2;
	mpid_pkg::pid_state_t      st_s2;

	// stage 3: error
	logic signed [mpid_pkg::ERR_W-1:0] blend;
	logic signed [mpid_pkg::ERR_W-1:0] err_s3;
	mpid_pkg::pid_state_t              st_s3;

	// stage 4: products
	logic signed [mpid_pkg::PROD_W-1:0] p0_s4, p1_s4, p2_s4;
	logic signed [mpid_pkg::ERR_W-1:0]  err_s4, e1_s4;
	logic signed [mpid_pkg::RAW_W-1:0]  y1_s4;

	// stage 5: floored increment
	logic signed [mpid_pkg::ACC_W-1:0] acc;
	logic signed [mpid_pkg::SH_W-1:0]  sh_s5;
	logic signed [mpid_pkg::ERR_W-1:0] err_s5, e1_s5;
	logic signed [mpid_pkg::RAW_W-1:0] y1_s5;

	// stage 6: saturated output
	logic signed [mpid_pkg::YS_W-1:0]  y_sum;
	logic signed [mpid_pkg::RAW_W-1:0] y_sat;
	logic signed [mpid_pkg::RAW_W-1:0] y_s6;

	// output register
	logic [mpid_pkg::DUTY_IN_W+mpid_pkg::DUTY_MUL_W-1:0] duty_prod;
	logic [mpid_pkg::DUTY_W-1:0]       duty;
	logic [mpid_pkg::CH_W-1:0]         out_channel_q;
	logic [mpid_pkg::DUTY_W-1:0]       duty_q;
	logic signed [mpid_pkg::RAW_W-1:0] raw_q;

	function automatic logic same_channel(stage_ctl_t c, logic [mpid_pkg::CH_W-1:0] ch);
		return c.vld && c.inr && (c.ch == ch);
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= mpid_pkg::SETPOINT_RESET;
			gain_p_q   <= mpid_pkg::GAIN_P_RESET;
			gain_i_q   <= mpid_pkg::GAIN_I_RESET;
			gain_d_q   <= mpid_pkg::GAIN_D_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mpid_pkg::CFG_SETPOINT: setpoint_q <= cfg_data[mpid_pkg::SP_W-1:0];
				mpid_pkg::CFG_GAIN_P:   gain_p_q   <= cfg_data[mpid_pkg::GAIN_W-1:0];
				mpid_pkg::CFG_GAIN_I:   gain_i_q   <= cfg_data[mpid_pkg::GAIN_W-1:0];
				mpid_pkg::CFG_GAIN_D:   gain_d_q   <= cfg_data[mpid_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// a0 = kp+ki+kd, a1 = -(kp+2kd), a2 = kd
	assign a1_mag = mpid_pkg::A_W'(gain_p_q) + {1'b0, gain_d_q, 1'b0};

	always_ff @(posedge clk) begin
		coef_a0_q <= mpid_pkg::A_W'(gain_p_q) + mpid_pkg::A_W'(gain_i_q)
			+ mpid_pkg::A_W'(gain_d_q);
		coef_a1_q <= -$signed({1'b0, a1_mag});
		coef_a2_q <= $signed({1'b0, gain_d_q});
	end

	// stall chain: a stage moves when it is empty or its successor moves
	assign en_out = !out_valid_q || result.ready;
	assign en_s6  = !ctl_s6.vld || en_out;
	assign en_s5  = !ctl_s5.vld || en_s6;
	assign en_s4  = !ctl_s4.vld || en_s5;
	assign en_s3  = !ctl_s3.vld || en_s4;
	assign en_s2  = !ctl_s2.vld || en_s3;
	assign en_s1  = !ctl_s1.vld || en_s2;

	assign in_range_in = 32'(reading.channel) < mpid_pkg::NUM_CHANNELS;
	assign rd_addr     = mpid_pkg::CH_AW'(reading.channel);

	// interlock: the channel is still between its ram read and its write-back
	assign hazard = in_range_in && (same_channel(ctl_s1, reading.channel)
		|| same_channel(ctl_s2, reading.channel) || same_channel(ctl_s3, reading.channel)
		|| same_channel(ctl_s4, reading.channel) || same_channel(ctl_s5, reading.channel));

	assign reading.ready = en_s1 && !hazard;
	assign accept        = reading.valid && reading.ready;

	// 9*sample + heater, then magnitude for the reciprocal divide
	assign sum9 = (mpid_pkg::SUM_W'(reading.sample_temp) <<< 3)
		+ mpid_pkg::SUM_W'(reading.sample_temp) + mpid_pkg::SUM_W'(reading.heater_temp);
	assign sum_neg = sum9[mpid_pkg::SUM_W-1];
	assign sum_mag = sum_neg ? mpid_pkg::MAG_W'(-sum9) : mpid_pkg::MAG_W'(sum9);

	// channel state memory
	assign ram_we    = en_s6 && ctl_s5.vld && ctl_s5.inr;
	assign ram_waddr = mpid_pkg::CH_AW'(ctl_s5.ch);
	assign ram_wdata = '{e1: err_s5, e2: e1_s5, y1: y_sat};

	mpid_ram #(
		.WIDTH (mpid_pkg::MEM_W),
		.DEPTH (mpid_pkg::NUM_CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept && in_range_in),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// pipeline control and entry markers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			ctl_s4      <= '0;
			ctl_s5      <= '0;
			ctl_s6      <= '0;
			out_valid_q <= 1'b0;
			ent_valid_q <= '0;
		end else begin
			if (en_s1) ctl_s1 <= '{vld: accept, inr: in_range_in, ch: reading.channel};
			if (en_s2) ctl_s2 <= ctl_s1;
			if (en_s3) ctl_s3 <= ctl_s2;
			if (en_s4) ctl_s4 <= ctl_s3;
			if (en_s5) ctl_s5 <= ctl_s4;
			if (en_s6) ctl_s6 <= ctl_s5;
			if (en_out) out_valid_q <= ctl_s6.vld;
			if (ram_we) ent_valid_q[ram_waddr] <= 1'b1;
		end
	end

	// divide by ten, truncating toward zero through sign and magnitude
	assign div_prod = mag_s1 * mpid_pkg::DIV10_MUL;
	assign blend    = neg_s2 ? -$signed({1'b0, q_s2}) : $signed({1'b0, q_s2});

	// three coefficient products summed, arithmetic shift gives the floor
	assign acc = mpid_pkg::ACC_W'(p0_s4) + mpid_pkg::ACC_W'(p1_s4) + mpid_pkg::ACC_W'(p2_s4);

	// accumulate and saturate to 48 bits
	assign y_sum = mpid_pkg::YS_W'(y1_s5) + mpid_pkg::YS_W'(sh_s5);

	always_comb begin
		if (y_sum[mpid_pkg::YS_W-1] != y_sum[mpid_pkg::YS_W-2]) begin
			y_sat = y_sum[mpid_pkg::YS_W-1] ? {1'b1, {(mpid_pkg::RAW_W-1){1'b0}}}
				: {1'b0, {(mpid_pkg::RAW_W-1){1'b1}}};
		end else begin
			y_sat = y_sum[mpid_pkg::RAW_W-1:0];
		end
	end

	// milli-percent to whole percent, clamped to the duty range
	assign duty_prod = y_s6[mpid_pkg::DUTY_IN_W-1:0] * mpid_pkg::DUTY_MUL;

	always_comb begin
		if (y_s6 < 0) begin
			duty = '0;
		end else if (y_s6 >= mpid_pkg::DUTY_FULL_MILLI) begin
			duty = mpid_pkg::DUTY_MAX;
		end else begin
			duty = duty_prod[mpid_pkg::DUTY_SHIFT +: mpid_pkg::DUTY_W];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en_s1) begin
			neg_s1 <= sum_neg;
			mag_s1 <= sum_mag;
			hit_s1 <= in_range_in && ent_valid_q[rd_addr];
		end
		if (en_s2) begin
			q_s2   <= div_prod[mpid_pkg::DIV10_SHIFT +: mpid_pkg::Q_W];
			neg_s2 <= neg_s1;
			st_s2  <= hit_s1 ? ram_rdata : '0;
		end
		if (en_s3) begin
			err_s3 <= mpid_pkg::ERR_W'(setpoint_q) - blend;
			st_s3  <= st_s2;
		end
		if (en_s4) begin
			p0_s4  <= $signed({1'b0, coef_a0_q}) * err_s3;
			p1_s4  <= coef_a1_q * st_s3.e1;
			p2_s4  <= coef_a2_q * st_s3.e2;
			err_s4 <= err_s3;
			e1_s4  <= st_s3.e1;
			y1_s4  <= st_s3.y1;
		end
		if (en_s5) begin
			sh_s5  <= acc[mpid_pkg::ACC_W-1:mpid_pkg::FRAC_W];
			err_s5 <= err_s4;
			e1_s5  <= e1_s4;
			y1_s5  <= y1_s4;
		end
		if (en_s6) begin
			y_s6 <= y_sat;
		end
		if (en_out) begin
			out_channel_q <= ctl_s6.ch;
			duty_q        <= ctl_s6.inr ? duty : '0;
			raw_q         <= ctl_s6.inr ? y_s6 : '0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.out_channel  = out_channel_q;
	assign result.duty_percent = duty_q;
	assign result.pid_raw      = raw_q;

	// two in-range requests in the update window never share a channel
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.vld && ctl_s1.inr && ctl_s5.vld && ctl_s5.inr) |-> (ctl_s1.ch != ctl_s5.ch))
		else $error("channel read while its write-back is pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s2.vld && ctl_s2.inr && ctl_s4.vld && ctl_s4.inr) |-> (ctl_s2.ch != ctl_s4.ch))
		else $error("same channel twice inside the pipe");

	// a write-back marks its entry as holding live state
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> ent_valid_q[$past(ram_waddr)])
		else $error("entry marker not set after write-back");

	// duty stays within full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (duty_q <= mpid_pkg::DUTY_MAX))
		else $error("duty above full scale");

endmodule
